// ===== src/asiq_pkg.sv =====
// shared constants for the array-backed key set
package asiq_pkg;

  localparam int unsigned CAPACITY_DEF = 64;
  localparam int unsigned KEY_BITS_DEF = 32;
  localparam int unsigned KEY_W        = 32;
  localparam int unsigned CMD_W        = 2;
  localparam int unsigned STATUS_W     = 2;
  localparam int unsigned ENTRIES_W    = 7;

  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_PRESENT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ABSENT  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

endpackage

// ===== src/asiq_mem.sv =====
// simple dual-port key memory with registered read
module asiq_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 32,
  parameter int unsigned AW    = 6
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/asiq_ctrl.sv =====
// search, append and shift-down sequencer with output register
module asiq_ctrl #(
  parameter int unsigned CAPACITY = 64,
  parameter int unsigned KEY_BITS = 32,
  parameter int unsigned AW       = 6,
  parameter int unsigned CW       = 7
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [asiq_pkg::CMD_W-1:0]        cmd_i,
  input  logic [asiq_pkg::KEY_W-1:0]        key_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [asiq_pkg::STATUS_W-1:0]     status_o,
  output logic                              present_o,
  output logic [asiq_pkg::ENTRIES_W-1:0]    entries_o,
  output logic                              mem_we_o,
  output logic [AW-1:0]                     mem_waddr_o,
  output logic [KEY_BITS-1:0]               mem_wdata_o,
  output logic [AW-1:0]                     mem_raddr_o,
  input  logic [KEY_BITS-1:0]               mem_rdata_i
);
  import asiq_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SEARCH = 2'd1;
  localparam logic [1:0] S_SHIFT  = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  logic [1:0]           state_q, state_d;
  logic [CW-1:0]        count_q, count_d;
  logic                 out_valid_q, out_valid_d;
  logic [CMD_W-1:0]     cmd_q, cmd_d;
  logic [KEY_BITS-1:0]  key_q, key_d;
  logic [AW-1:0]        idx_q, idx_d;
  logic [STATUS_W-1:0]  status_q, status_d;
  logic                 held_q, held_d;
  logic [STATUS_W-1:0]  out_status_q, out_status_d;
  logic                 out_present_q, out_present_d;
  logic [ENTRIES_W-1:0] out_entries_q, out_entries_d;

  logic [KEY_BITS-1:0]  key_m;
  logic [ENTRIES_W-1:0] entries_w;
  logic [CW:0]          idx_x;
  logic [CW:0]          count_x;
  logic                 hit;
  logic                 last;

  if (KEY_BITS <= KEY_W) begin : g_key_narrow
    assign key_m = key_i[KEY_BITS-1:0];
  end else begin : g_key_wide
    assign key_m = {{(KEY_BITS-KEY_W){1'b0}}, key_i};
  end

  if (CW >= ENTRIES_W) begin : g_ent_trunc
    assign entries_w = count_q[ENTRIES_W-1:0];
  end else begin : g_ent_ext
    assign entries_w = {{(ENTRIES_W-CW){1'b0}}, count_q};
  end

  assign idx_x   = (CW+1)'(idx_q);
  assign count_x = {1'b0, count_q};
  assign hit     = (count_q != '0) && (mem_rdata_i == key_q);
  assign last    = (idx_x + (CW+1)'(1)) >= count_x;

  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    cmd_d         = cmd_q;
    key_d         = key_q;
    idx_d         = idx_q;
    status_d      = status_q;
    held_d        = held_q;
    out_valid_d   = out_valid_q;
    out_status_d  = out_status_q;
    out_present_d = out_present_q;
    out_entries_d = out_entries_q;
    mem_we_o      = 1'b0;
    mem_waddr_o   = idx_q;
    mem_wdata_o   = mem_rdata_i;
    mem_raddr_o   = AW'(idx_x + (CW+1)'(1));

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        mem_raddr_o = '0;
        if (in_valid_i) begin
          cmd_d   = cmd_i;
          key_d   = key_m;
          idx_d   = '0;
          state_d = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (hit || last) begin
          held_d  = hit;
          state_d = S_FINISH;
          case (cmd_q)
            CMD_ADD: begin
              if (hit) begin
                status_d = ST_PRESENT;
              end else if (count_q >= CW'(CAPACITY)) begin
                status_d = ST_FULL;
              end else begin
                mem_we_o    = 1'b1;
                mem_waddr_o = AW'(count_q);
                mem_wdata_o = key_q;
                count_d     = count_q + 1'b1;
                status_d    = ST_DONE;
              end
            end
            CMD_REMOVE: begin
              if (!hit) begin
                status_d = ST_ABSENT;
              end else begin
                status_d = ST_DONE;
                if (!last) begin
                  state_d = S_SHIFT;
                end else begin
                  count_d = count_q - 1'b1;
                end
              end
            end
            default: begin
              status_d = hit ? ST_PRESENT : ST_ABSENT;
            end
          endcase
        end else begin
          idx_d = AW'(idx_x + (CW+1)'(1));
        end
      end
      S_SHIFT: begin
        mem_raddr_o = AW'(idx_x + (CW+1)'(2));
        mem_we_o    = 1'b1;
        mem_waddr_o = idx_q;
        mem_wdata_o = mem_rdata_i;
        if ((idx_x + (CW+1)'(2)) < count_x) begin
          idx_d = AW'(idx_x + (CW+1)'(1));
        end else begin
          count_d = count_q - 1'b1;
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d   = 1'b1;
          out_status_d  = status_q;
          out_present_d = held_q;
          out_entries_d = entries_w;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q         <= cmd_d;
    key_q         <= key_d;
    idx_q         <= idx_d;
    status_q      <= status_d;
    held_q        <= held_d;
    out_status_q  <= out_status_d;
    out_present_q <= out_present_d;
    out_entries_q <= out_entries_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign present_o   = out_present_q;
  assign entries_o   = out_entries_q;

endmodule

// ===== src/array_set_insert_remove_query_unit.sv =====
// top level of the array-backed key set with linear search
//
//  channel  direction  signals                          payload
//  in       input      in_valid_i / in_ready_o          cmd_i, key_i
//  out      output     out_valid_o / out_ready_i        status_o, present_o, entries_o
//
// one item at a time: accept it, compare the stored entries in turn until a
// match or the end, move each later entry down one place on a remove, then
// load the output register; entries are read through the single read port of
// the key memory
// reset clears the live count, the state and the output valid flag; the key memory needs no clearing
// a waiting result holds in the output register while the next item runs
module array_set_insert_remove_query_unit #(
  parameter int unsigned CAPACITY = asiq_pkg::CAPACITY_DEF,
  parameter int unsigned KEY_BITS = asiq_pkg::KEY_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [asiq_pkg::CMD_W-1:0]     cmd_i,
  input  logic [asiq_pkg::KEY_W-1:0]     key_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [asiq_pkg::STATUS_W-1:0]  status_o,
  output logic                           present_o,
  output logic [asiq_pkg::ENTRIES_W-1:0] entries_o
);
  import asiq_pkg::*;

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [KEY_BITS-1:0] mem_wdata;
  logic [AW-1:0]       mem_raddr;
  logic [KEY_BITS-1:0] mem_rdata;

  asiq_mem #(
    .DEPTH (CAPACITY),
    .WIDTH (KEY_BITS),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  asiq_ctrl #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS),
    .AW       (AW),
    .CW       (CW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cmd_i       (cmd_i),
    .key_i       (key_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_o    (status_o),
    .present_o   (present_o),
    .entries_o   (entries_o),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

endmodule
